@@ sv/s2pd_pkg.sv @@
package s2pd_pkg;

    // Widest digit accepted, in bits
    localparam int unsigned MAX_DIGIT_BITS = 5;

    // Status codes carried on each result item
    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_WIDTH = 1'b1;

    // One input item
    typedef struct packed {
        logic signed [63:0] value;
        logic [2:0]         digit_bits;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [7:0] character;
        logic       negative;
        logic       status;
        logic       last;
    } out_item_t;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_REJECT
    } state_t;

    // Map a digit 0..31 to its ASCII character ('0'-'9', 'A'-'V')
    function automatic logic [7:0] digit_char(input logic [4:0] digit);
        logic [7:0] d;
        d = {3'b000, digit};
        if (digit < 5'd10)
        begin
            digit_char = 8'h30 + d;
        end
        else
        begin
            digit_char = 8'h37 + d;
        end
    endfunction

endpackage

@@ sv/signed_to_pow2_base_digits.sv @@
// Channel | Ports                   | Handshake
// --------+-------------------------+------------------------------------------
// in      | operand (in_item_t)     | taken at a clock edge with start & !busy
// out     | result (out_item_t)     | valid for one cycle while strobe is high
//
// While a valid item is being converted, busy stays high: one shift of the
// left-aligned magnitude register by r bits per cycle, leading zero digits
// dropped silently, then one result per cycle from the first nonzero or final digit on.
// A rejected digit width goes through the reject state and gives a single result.
// Results are registered and leave in the cycle after the shift that produced them.
// Reset is asynchronous and needs no clearing pass; the receiver cannot stall.
module signed_to_pow2_base_digits
    import s2pd_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  operand,
    output logic      strobe,
    output out_item_t result
);

    // Headroom above the magnitude so the top digit always sits at the MSB end
    localparam int unsigned PAD_W = MAX_DIGIT_BITS - 1;
    localparam int unsigned SW    = VALUE_WIDTH + PAD_W;
    localparam int unsigned CW    = $clog2(VALUE_WIDTH + 1);

    // Digit count of a full-width magnitude for each digit width
    localparam int unsigned D1 = VALUE_WIDTH;
    localparam int unsigned D2 = (VALUE_WIDTH + 1) / 2;
    localparam int unsigned D3 = (VALUE_WIDTH + 2) / 3;
    localparam int unsigned D4 = (VALUE_WIDTH + 3) / 4;
    localparam int unsigned D5 = (VALUE_WIDTH + 4) / 5;

    // Left shift at load that aligns the top digit with the register MSB
    localparam int unsigned L1 = PAD_W - (D1 * 1 - VALUE_WIDTH);
    localparam int unsigned L2 = PAD_W - (D2 * 2 - VALUE_WIDTH);
    localparam int unsigned L3 = PAD_W - (D3 * 3 - VALUE_WIDTH);
    localparam int unsigned L4 = PAD_W - (D4 * 4 - VALUE_WIDTH);
    localparam int unsigned L5 = PAD_W - (D5 * 5 - VALUE_WIDTH);

    state_t              state_reg, state_next;
    logic [SW-1:0]       shift_reg, shift_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [2:0]          width_reg, width_next;
    logic                neg_reg, neg_next;
    logic                seen_reg, seen_next;
    logic                strobe_reg, strobe_next;
    out_item_t           result_reg, result_next;

    logic [VALUE_WIDTH-1:0] value_low;
    logic                   value_neg;
    logic [VALUE_WIDTH-1:0] magnitude;
    logic                   width_ok;
    logic [CW-1:0]          load_count;
    logic [2:0]             load_shift;
    logic [4:0]             top_digit;
    logic [SW-1:0]          shifted;
    logic                   emit;
    logic                   final_digit;

    assign busy   = (state_reg != ST_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;

    // Take the magnitude of the low VALUE_WIDTH bits
    assign value_low = operand.value[VALUE_WIDTH-1:0];
    assign value_neg = value_low[VALUE_WIDTH-1];
    assign magnitude = value_neg ? (~value_low + 1'b1) : value_low;
    assign width_ok  = (operand.digit_bits >= 3'd1) && (operand.digit_bits <= 3'd5);

    // Look up digit count and alignment for the incoming digit width
    always_comb
    begin
        unique case (operand.digit_bits)
            3'd1:
            begin
                load_count = CW'(D1);
                load_shift = 3'(L1);
            end
            3'd2:
            begin
                load_count = CW'(D2);
                load_shift = 3'(L2);
            end
            3'd3:
            begin
                load_count = CW'(D3);
                load_shift = 3'(L3);
            end
            3'd4:
            begin
                load_count = CW'(D4);
                load_shift = 3'(L4);
            end
            3'd5:
            begin
                load_count = CW'(D5);
                load_shift = 3'(L5);
            end
            default:
            begin
                load_count = '0;
                load_shift = '0;
            end
        endcase
    end

    // Shared shift unit: read the top digit and advance by r bits
    always_comb
    begin
        unique case (width_reg)
            3'd1:
            begin
                top_digit = {4'b0000, shift_reg[SW-1]};
                shifted   = shift_reg << 1;
            end
            3'd2:
            begin
                top_digit = {3'b000, shift_reg[SW-1 -: 2]};
                shifted   = shift_reg << 2;
            end
            3'd3:
            begin
                top_digit = {2'b00, shift_reg[SW-1 -: 3]};
                shifted   = shift_reg << 3;
            end
            3'd4:
            begin
                top_digit = {1'b0, shift_reg[SW-1 -: 4]};
                shifted   = shift_reg << 4;
            end
            3'd5:
            begin
                top_digit = shift_reg[SW-1 -: 5];
                shifted   = shift_reg << 5;
            end
            default:
            begin
                top_digit = '0;
                shifted   = shift_reg;
            end
        endcase
    end

    assign final_digit = (count_reg == CW'(1));
    assign emit        = seen_reg || (top_digit != 5'd0) || final_digit;

    // Sequencer: next state and result
    always_comb
    begin
        state_next  = state_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        width_next  = width_reg;
        neg_next    = neg_reg;
        seen_next   = seen_reg;
        strobe_next = 1'b0;
        result_next = result_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    width_next = operand.digit_bits;
                    neg_next   = value_neg;
                    seen_next  = 1'b0;
                    if (width_ok)
                    begin
                        shift_next = {{PAD_W{1'b0}}, magnitude} << load_shift;
                        count_next = load_count;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        shift_next = '0;
                        count_next = '0;
                        state_next = ST_REJECT;
                    end
                end
            end
            ST_RUN:
            begin
                // Drop leading zero digits, send the rest
                shift_next = shifted;
                count_next = count_reg - CW'(1);
                seen_next  = emit;
                if (emit)
                begin
                    strobe_next           = 1'b1;
                    result_next.character = digit_char(top_digit);
                    result_next.negative  = neg_reg;
                    result_next.status    = STATUS_OK;
                    result_next.last      = final_digit;
                end
                if (final_digit)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_REJECT:
            begin
                strobe_next           = 1'b1;
                result_next.character = 8'h00;
                result_next.negative  = neg_reg;
                result_next.status    = STATUS_BAD_WIDTH;
                result_next.last      = 1'b1;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
            count_reg  <= '0;
            width_reg  <= '0;
            neg_reg    <= 1'b0;
            seen_reg   <= 1'b0;
            shift_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            count_reg  <= count_next;
            width_reg  <= width_next;
            neg_reg    <= neg_next;
            seen_reg   <= seen_next;
            shift_reg  <= shift_next;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

@@ tb/tb_signed_to_pow2_base_digits.sv @@
`timescale 1ns / 100ps

module tb_signed_to_pow2_base_digits;
    import s2pd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 160;
    localparam int unsigned DRAIN_CYCLES = 80;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  operand;
    logic      strobe;
    out_item_t result;

    // Characters still owed by the block, oldest first
    out_item_t   char_queue[$];
    int unsigned error_count;
    int unsigned items_sent;
    int unsigned chars_checked;
    int unsigned cycle_count;

    signed_to_pow2_base_digits u_top
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .operand (operand),
        .strobe  (strobe),
        .result  (result)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Work out the characters one conversion should give and queue them
    function automatic void expand_digits(input in_item_t item);
        logic [63:0] raw;
        logic [63:0] mag;
        logic [63:0] digit;
        logic        neg;
        int unsigned width;
        int unsigned bit_len;
        int unsigned count;
        out_item_t   exp_char;
        begin
            raw   = item.value;
            width = 32'(item.digit_bits);
            neg   = raw[63];
            mag   = neg ? (~raw + 64'd1) : raw;
            // Reject widths outside 1..MAX_DIGIT_BITS with a single status item
            if (width < 1 || width > MAX_DIGIT_BITS)
            begin
                exp_char.character = 8'h00;
                exp_char.negative  = neg;
                exp_char.status    = STATUS_BAD_WIDTH;
                exp_char.last      = 1'b1;
                char_queue.push_back(exp_char);
                return;
            end
            bit_len = 0;
            for (int i = 0; i < 64; i++)
            begin
                if (mag[i])
                begin
                    bit_len = i + 1;
                end
            end
            count = (bit_len + width - 1) / width;
            // Zero still sends one '0'
            if (count == 0)
            begin
                count = 1;
            end
            for (int k = count; k > 0; k--)
            begin
                digit = (mag >> ((k - 1) * width)) & ((64'd1 << width) - 64'd1);
                exp_char.character = (digit < 10) ? 8'h30 + digit[7:0]
                                                  : 8'h41 + digit[7:0] - 8'd10;
                exp_char.negative  = neg;
                exp_char.status    = STATUS_OK;
                exp_char.last      = (k == 1);
                char_queue.push_back(exp_char);
            end
        end
    endfunction

    // Offer one item and hold it until the block takes it
    task automatic send_item(input logic [63:0] val, input logic [2:0] width);
        in_item_t item;
        begin
            item.value      = val;
            item.digit_bits = width;
            start   <= 1'b1;
            operand <= item;
            @(posedge clk);
            while (busy)
            begin
                @(posedge clk);
            end
            expand_digits(item);
            items_sent++;
        end
    endtask

    // Drop start for a number of cycles
    task automatic pause_sender(input int unsigned cycles);
        begin
            if (cycles != 0)
            begin
                start <= 1'b0;
                repeat (cycles) @(posedge clk);
            end
        end
    endtask

    // Zero, one, minus one, the largest and the most negative value, and alternating bit patterns
    task automatic test_extremes;
        begin
            send_item(64'd0, 3'd1);
            send_item(64'd0, 3'd5);
            pause_sender(2);
            send_item(64'd1, 3'd1);
            send_item(-64'sd1, 3'd1);
            send_item(64'h7FFF_FFFF_FFFF_FFFF, 3'd1);
            pause_sender(1);
            send_item(64'h7FFF_FFFF_FFFF_FFFF, 3'd5);
            send_item(64'h8000_0000_0000_0000, 3'd1);
            send_item(64'h8000_0000_0000_0000, 3'd5);
            send_item(64'hAAAA_AAAA_AAAA_AAAA, 3'd4);
            send_item(64'h5555_5555_5555_5555, 3'd3);
            pause_sender(3);
        end
    endtask

    // One value through every valid digit width, then its negation and 31 as one base-32 digit
    task automatic test_each_width;
        begin
            for (int w = 1; w <= MAX_DIGIT_BITS; w++)
            begin
                send_item(64'h0123_4567_89AB_CDEF, w[2:0]);
            end
            send_item(-64'sh0123_4567_89AB_CDEF, 3'd2);
            send_item(64'd31, 3'd5);
            pause_sender(4);
        end
    endtask

    // Widths 0, 6 and 7 give one status item, sign still reported
    task automatic test_invalid_width;
        begin
            send_item(-64'sd5, 3'd0);
            send_item(64'd12345, 3'd6);
            pause_sender(1);
            send_item(64'd0, 3'd7);
            send_item(64'h8000_0000_0000_0000, 3'd7);
            pause_sender(2);
        end
    endtask

    // Random values of random length in bursts with random gaps
    task automatic test_random;
        logic [63:0] val;
        logic [2:0]  width;
        int unsigned burst;
        int unsigned burst_count;
        int unsigned sent;
        begin
            sent        = 0;
            burst_count = 0;
            while (sent < RANDOM_ITEMS)
            begin
                burst_count++;
                burst = (burst_count % 5 == 0) ? 12 : $urandom_range(1, 8);
                for (int i = 0; i < burst; i++)
                begin
                    val = {$urandom(), $urandom()};
                    case ($urandom_range(0, 9))
                        0: val = 64'd0;
                        1: val = 64'h8000_0000_0000_0000;
                        2, 3, 4, 5: val = val >> $urandom_range(0, 63);
                        default: ;
                    endcase
                    if ($urandom_range(0, 1))
                    begin
                        val = -val;
                    end
                    if ($urandom_range(0, 9) == 0)
                    begin
                        width = 3'($urandom_range(0, 2));
                        if (width != 3'd0)
                        begin
                            width = width + 3'd5;
                        end
                    end
                    else
                    begin
                        width = 3'($urandom_range(1, MAX_DIGIT_BITS));
                    end
                    send_item(val, width);
                    sent++;
                end
                // Keep every fifth burst free of gaps
                if (burst_count % 5 != 0)
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        pause_sender($urandom_range(4, 70));
                    end
                    else
                    begin
                        pause_sender($urandom_range(0, 3));
                    end
                end
            end
        end
    endtask

    // Compare each strobed character with the oldest one owed
    always @(posedge clk)
    begin
        out_item_t exp_char;
        if (rst_n && strobe)
        begin
            if (char_queue.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual %h", $time, result);
                error_count++;
            end
            else
            begin
                exp_char = char_queue.pop_front();
                chars_checked++;
                if (result.character !== exp_char.character)
                begin
                    $display("%0t: character expected %h actual %h",
                             $time, exp_char.character, result.character);
                    error_count++;
                end
                if (result.negative !== exp_char.negative)
                begin
                    $display("%0t: negative expected %b actual %b",
                             $time, exp_char.negative, result.negative);
                    error_count++;
                end
                if (result.status !== exp_char.status)
                begin
                    $display("%0t: status expected %b actual %b",
                             $time, exp_char.status, result.status);
                    error_count++;
                end
                if (result.last !== exp_char.last)
                begin
                    $display("%0t: last expected %b actual %b",
                             $time, exp_char.last, result.last);
                    error_count++;
                end
            end
        end
    end

    // End the run if it hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d items still owed", $time, char_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Reset, run each test in turn, then drain
    initial
    begin
        error_count   = 0;
        items_sent    = 0;
        chars_checked = 0;
        cycle_count   = 0;
        rst_n         = 1'b0;
        start         = 1'b0;
        operand       = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes;
        test_each_width;
        test_invalid_width;
        test_random;

        start <= 1'b0;
        while (char_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Converted %0d values and checked %0d output characters,", items_sent,
                 chars_checked);
        $display("covering zero, sign extremes, all digit widths and rejected widths.");
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
